FILE: sv/prq_pkg.sv
`default_nettype none

package prq_pkg;

  // Sizes of the queue tables.
  localparam int Priorities = 32;
  localparam int Threads    = 16;
  localparam int LvlW       = $clog2(Priorities);
  localparam int TidW       = $clog2(Threads);

  typedef logic [LvlW-1:0] lvl_t;
  typedef logic [TidW-1:0] tid_t;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_SCHEDULE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_LINK,
    ST_RM_THR,
    ST_RM_LVL,
    ST_RM_PREV,
    ST_SCH_RD,
    ST_RESP
  } state_e;

  // One entry of the level memory: first and last thread of a level.
  typedef struct packed {
    tid_t head;
    tid_t tail;
  } lvl_ent_t;

  // One entry of the thread memory: links and the level it is queued at.
  typedef struct packed {
    tid_t nxt_tid;
    tid_t prv_tid;
    lvl_t qlvl;
  } thr_ent_t;

  // Field write enables of the two memories.
  typedef struct packed {
    logic head;
    logic tail;
  } lvl_we_t;

  typedef struct packed {
    logic nxt_tid;
    logic prv_tid;
    logic qlvl;
  } thr_we_t;

endpackage

`default_nettype wire

FILE: sv/priority_ready_queue_scheduler_core.sv
// An item is taken only when idle or as the last result is loaded. An insert reads
// its level, writes the level and thread, then links the old tail if others wait;
// a remove reads the thread, then its level, unlinks it and may fix the successor;
// a schedule reads the best level; an empty schedule or ignored command has no steps.
// Reset clears the ready bitmap, queued flags, running thread and control; the link
// memories are not cleared and there is no clearing pass.
`default_nettype none

module priority_ready_queue_scheduler_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire [1:0]           command_i,
  input  wire prq_pkg::tid_t  thread_id_i,
  input  wire prq_pkg::lvl_t  thread_priority_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output prq_pkg::tid_t       chosen_thread_o,
  output prq_pkg::lvl_t       chosen_priority_o,
  output prq_pkg::tid_t       previous_thread_o,
  output logic                switch_needed_o,
  output logic                none_ready_o,
  output logic                status_o
);

  prq_pkg::state_e state_q, state_d;

  // Item registers.
  prq_pkg::tid_t tid_q;
  prq_pkg::lvl_t lvl_q, lvl_d;
  prq_pkg::tid_t prev_q, prev_d;
  logic          sw_q, sw_d, none_q, none_d, st_q, st_d;

  // Scheduler state in flip-flops.
  logic [prq_pkg::Priorities-1:0] ready_q, ready_d;
  logic [prq_pkg::Threads-1:0]    queued_q, queued_d;
  prq_pkg::tid_t                  run_thread_q, run_thread_d;
  prq_pkg::lvl_t                  run_prio_q, run_prio_d;
  logic                           run_valid_q, run_valid_d;

  // Output register.
  logic          out_valid_q;
  prq_pkg::tid_t out_thread_q, out_prev_q;
  prq_pkg::lvl_t out_prio_q;
  logic          out_sw_q, out_none_q, out_st_q;

  // Link memories.
  prq_pkg::lvl_ent_t lvl_mem [prq_pkg::Priorities];
  prq_pkg::thr_ent_t thr_mem [prq_pkg::Threads];
  prq_pkg::lvl_ent_t lvl_rd_q, lvl_wdata;
  prq_pkg::thr_ent_t thr_rd_q, thr_wdata;
  logic              lvl_rd_en, thr_rd_en;
  prq_pkg::lvl_t     lvl_rd_addr, lvl_wr_addr;
  prq_pkg::tid_t     thr_rd_addr, thr_wr_addr;
  prq_pkg::lvl_we_t  lvl_we;
  prq_pkg::thr_we_t  thr_we;

  logic          out_free, accept_ok, in_accept, out_load;
  prq_pkg::lvl_t in_pri_sat, best_lvl;
  logic          ins_bit, rm_only, sch_switch;
  prq_pkg::tid_t rm_hd, rm_tl, rm_nx, rm_pv;
  prq_pkg::lvl_t rm_lvl;

  // Handshake: items are taken when idle or while the result slot drains.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == prq_pkg::ST_RESP) && out_free;
  assign accept_ok  = (state_q == prq_pkg::ST_IDLE) || out_load;
  assign in_accept  = in_valid_i && accept_ok;
  assign in_stall_o = !accept_ok;

  // Out-of-range priorities fall onto the lowest level.
  assign in_pri_sat = (thread_priority_i > prq_pkg::lvl_t'(prq_pkg::Priorities - 1)) ?
                      prq_pkg::lvl_t'(prq_pkg::Priorities - 1) : thread_priority_i;

  // Lowest set bit of the ready bitmap is the best level.
  always_comb begin
    best_lvl = prq_pkg::lvl_t'(prq_pkg::Priorities - 1);
    for (int i = prq_pkg::Priorities - 1; i >= 0; i--) begin
      if (ready_q[i]) best_lvl = prq_pkg::lvl_t'(i);
    end
  end

  // Values read back from the memories.
  assign ins_bit    = ready_q[lvl_q];
  assign rm_hd      = lvl_rd_q.head;
  assign rm_tl      = lvl_rd_q.tail;
  assign rm_nx      = thr_rd_q.nxt_tid;
  assign rm_pv      = thr_rd_q.prv_tid;
  assign rm_lvl     = thr_rd_q.qlvl;
  assign rm_only    = (rm_hd == tid_q) && (rm_tl == tid_q);
  assign sch_switch = !run_valid_q || (lvl_rd_q.head != run_thread_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      prq_pkg::ST_IDLE, prq_pkg::ST_RESP: begin
        if (out_load) state_d = prq_pkg::ST_IDLE;
        if (in_accept) begin
          case (prq_pkg::cmd_e'(command_i))
            prq_pkg::CMD_INSERT:
              state_d = queued_q[thread_id_i] ? prq_pkg::ST_RESP : prq_pkg::ST_INS_RD;
            prq_pkg::CMD_REMOVE:
              state_d = queued_q[thread_id_i] ? prq_pkg::ST_RM_THR : prq_pkg::ST_RESP;
            prq_pkg::CMD_SCHEDULE:
              state_d = (ready_q == '0) ? prq_pkg::ST_RESP : prq_pkg::ST_SCH_RD;
            default:
              state_d = prq_pkg::ST_RESP;
          endcase
        end
      end
      prq_pkg::ST_INS_RD:   state_d = ins_bit ? prq_pkg::ST_INS_LINK : prq_pkg::ST_RESP;
      prq_pkg::ST_INS_LINK: state_d = prq_pkg::ST_RESP;
      prq_pkg::ST_RM_THR:   state_d = prq_pkg::ST_RM_LVL;
      prq_pkg::ST_RM_LVL:   state_d = (rm_tl != tid_q) ? prq_pkg::ST_RM_PREV : prq_pkg::ST_RESP;
      prq_pkg::ST_RM_PREV:  state_d = prq_pkg::ST_RESP;
      prq_pkg::ST_SCH_RD:   state_d = prq_pkg::ST_RESP;
      default:              state_d = prq_pkg::ST_IDLE;
    endcase
  end

  // Memory accesses and state updates of each step.
  always_comb begin
    lvl_rd_en    = 1'b0;
    lvl_rd_addr  = in_pri_sat;
    thr_rd_en    = 1'b0;
    thr_rd_addr  = thread_id_i;
    lvl_we       = '0;
    lvl_wr_addr  = lvl_q;
    lvl_wdata    = '{head: tid_q, tail: tid_q};
    thr_we       = '0;
    thr_wr_addr  = tid_q;
    thr_wdata    = '{nxt_tid: tid_q, prv_tid: lvl_rd_q.tail, qlvl: lvl_q};
    ready_d      = ready_q;
    queued_d     = queued_q;
    run_thread_d = run_thread_q;
    run_prio_d   = run_prio_q;
    run_valid_d  = run_valid_q;
    lvl_d        = lvl_q;
    prev_d       = prev_q;
    sw_d         = sw_q;
    none_d       = none_q;
    st_d         = st_q;

    // Decode an accepted item and issue its first read.
    if (in_accept) begin
      prev_d = '0;
      sw_d   = 1'b0;
      none_d = 1'b0;
      st_d   = 1'b0;
      lvl_d  = in_pri_sat;
      case (prq_pkg::cmd_e'(command_i))
        prq_pkg::CMD_INSERT: begin
          st_d      = queued_q[thread_id_i];
          lvl_rd_en = 1'b1;
        end
        prq_pkg::CMD_REMOVE: begin
          st_d      = !queued_q[thread_id_i];
          thr_rd_en = 1'b1;
        end
        prq_pkg::CMD_SCHEDULE: begin
          none_d      = (ready_q == '0);
          lvl_d       = best_lvl;
          lvl_rd_en   = 1'b1;
          lvl_rd_addr = best_lvl;
        end
        default: st_d = 1'b1;
      endcase
    end

    case (state_q)
      // Append at the tail, or start a new level.
      prq_pkg::ST_INS_RD: begin
        lvl_we.tail     = 1'b1;
        lvl_we.head     = !ins_bit;
        thr_we.qlvl     = 1'b1;
        thr_we.prv_tid  = ins_bit;
        ready_d[lvl_q]  = 1'b1;
        queued_d[tid_q] = 1'b1;
      end
      // Link the old tail forward to the new thread.
      prq_pkg::ST_INS_LINK: begin
        thr_wr_addr    = lvl_rd_q.tail;
        thr_we.nxt_tid = 1'b1;
      end
      // The thread's level is known; read that level's head and tail.
      prq_pkg::ST_RM_THR: begin
        lvl_rd_en   = 1'b1;
        lvl_rd_addr = rm_lvl;
      end
      // Unlink: fix the level ends and the forward link of the predecessor.
      prq_pkg::ST_RM_LVL: begin
        queued_d[tid_q] = 1'b0;
        if (rm_only) begin
          ready_d[rm_lvl] = 1'b0;
        end else begin
          lvl_wr_addr    = rm_lvl;
          lvl_we.head    = (rm_hd == tid_q);
          lvl_we.tail    = (rm_tl == tid_q);
          lvl_wdata      = '{head: rm_nx, tail: rm_pv};
          thr_wr_addr    = rm_pv;
          thr_we.nxt_tid = (rm_hd != tid_q);
          thr_wdata      = '{nxt_tid: rm_nx, prv_tid: rm_pv, qlvl: rm_lvl};
        end
      end
      // Fix the backward link of the successor.
      prq_pkg::ST_RM_PREV: begin
        thr_wr_addr    = rm_nx;
        thr_we.prv_tid = 1'b1;
        thr_wdata      = '{nxt_tid: rm_nx, prv_tid: rm_pv, qlvl: rm_lvl};
      end
      // Switch to the head of the best level if it is not already running.
      prq_pkg::ST_SCH_RD: begin
        if (sch_switch) begin
          prev_d       = run_thread_q;
          run_thread_d = lvl_rd_q.head;
          run_prio_d   = lvl_q;
          run_valid_d  = 1'b1;
          sw_d         = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= prq_pkg::ST_IDLE;
      ready_q      <= '0;
      queued_q     <= '0;
      run_thread_q <= '0;
      run_prio_q   <= prq_pkg::lvl_t'(prq_pkg::Priorities - 1);
      run_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      ready_q      <= ready_d;
      queued_q     <= queued_d;
      run_thread_q <= run_thread_d;
      run_prio_q   <= run_prio_d;
      run_valid_q  <= run_valid_d;
      out_valid_q  <= out_load || (out_valid_q && out_stall_i);
    end
  end

  // Item and result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) tid_q <= thread_id_i;
    lvl_q  <= lvl_d;
    prev_q <= prev_d;
    sw_q   <= sw_d;
    none_q <= none_d;
    st_q   <= st_d;
    if (out_load) begin
      out_thread_q <= run_thread_q;
      out_prio_q   <= run_prio_q;
      out_prev_q   <= prev_q;
      out_sw_q     <= sw_q;
      out_none_q   <= none_q;
      out_st_q     <= st_q;
    end
  end

  // Level memory: head and tail per level, registered read.
  always_ff @(posedge clk_i) begin
    if (lvl_we.head) lvl_mem[lvl_wr_addr].head <= lvl_wdata.head;
    if (lvl_we.tail) lvl_mem[lvl_wr_addr].tail <= lvl_wdata.tail;
    if (lvl_rd_en) lvl_rd_q <= lvl_mem[lvl_rd_addr];
  end

  // Thread memory: links and queued level per thread, registered read.
  always_ff @(posedge clk_i) begin
    if (thr_we.nxt_tid) thr_mem[thr_wr_addr].nxt_tid <= thr_wdata.nxt_tid;
    if (thr_we.prv_tid) thr_mem[thr_wr_addr].prv_tid <= thr_wdata.prv_tid;
    if (thr_we.qlvl)    thr_mem[thr_wr_addr].qlvl    <= thr_wdata.qlvl;
    if (thr_rd_en) thr_rd_q <= thr_mem[thr_rd_addr];
  end

  assign out_valid_o       = out_valid_q;
  assign chosen_thread_o   = out_thread_q;
  assign chosen_priority_o = out_prio_q;
  assign previous_thread_o = out_prev_q;
  assign switch_needed_o   = out_sw_q;
  assign none_ready_o      = out_none_q;
  assign status_o          = out_st_q;

endmodule

`default_nettype wire

FILE: sv/prq_checker.sv
`default_nettype none

module prq_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_stall_o,
  input wire [1:0]          command_i,
  input wire prq_pkg::tid_t thread_id_i,
  input wire prq_pkg::lvl_t thread_priority_i,
  input wire                out_valid_o,
  input wire                out_stall_i,
  input wire prq_pkg::tid_t chosen_thread_o,
  input wire prq_pkg::lvl_t chosen_priority_o,
  input wire prq_pkg::tid_t previous_thread_o,
  input wire                switch_needed_o,
  input wire                none_ready_o,
  input wire                status_o
);

  // A stalled input item stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(command_i) &&
      $stable(thread_id_i) && $stable(thread_priority_i))
    else $error("stalled input item changed");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(chosen_thread_o) &&
      $stable(chosen_priority_o) && $stable(switch_needed_o) && $stable(status_o))
    else $error("stalled result changed");

  // Without a switch the previous thread reads as zero.
  a_prev_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !switch_needed_o |-> previous_thread_o == '0)
    else $error("previous thread set without a switch");

  // An empty bitmap gives neither a switch nor an ignored status.
  a_none_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && none_ready_o |-> !switch_needed_o && !status_o)
    else $error("none ready combined with switch or ignored status");

  // An ignored item never switches.
  a_ignored_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> !switch_needed_o && !none_ready_o)
    else $error("ignored item reported a schedule outcome");

endmodule

bind priority_ready_queue_scheduler_core prq_checker u_prq_checker (.*);

`default_nettype wire
